@@ hdl/hks_pkg.sv @@
// ----------------------------------------------------------------------------
// hks_pkg
// Shared types and constants for the hashed key set: field widths, item
// modes and the controller states.
// ----------------------------------------------------------------------------
package hks_pkg;

  localparam int KEY_W               = 16;
  localparam int MODE_W              = 2;
  localparam int DEF_NUM_BUCKETS     = 251;
  localparam int DEF_SLOTS_PER_BUCKET = 4;

  // code 3 is unused and behaves as a lookup
  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_UPDATE
  } state_t;

endpackage

@@ hdl/hashed_key_set.sv @@
// ----------------------------------------------------------------------------
// hashed_key_set
// Set of 16-bit message identifiers held in a bucketed hash table memory.
// ----------------------------------------------------------------------------
// Each item looks a key up, inserts it when absent, or removes it, and gives
// one result with the presence before and after the item and a flag for an
// insert refused by a full bucket. One memory row holds a whole bucket (valid
// bits and keys of all slots); the bucket is key modulo NUM_BUCKETS. An item
// passes three modulo pipeline stages (the first loads at the transfer edge), one
// for the registered row read and one to compare, write the row back and load the
// result register. The next item is taken only after that write-back, so one item
// is in flight at a time. A result waiting at the output only holds the next item
// at its write-back step. After reset a clearing pass writes every row empty,
// during which no item is taken.
module hashed_key_set
  import hks_pkg::*;
#(
  parameter int NUM_BUCKETS      = DEF_NUM_BUCKETS,
  parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [1:0] mode, [17:2] key
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] was_present, [1] now_present, [2] bucket_full
);

  localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SLT   = SLOTS_PER_BUCKET;

  typedef struct packed {
    logic [SLT-1:0]            vld;
    logic [SLT-1:0][KEY_W-1:0] keys;
  } row_t;

  row_t mem [NUM_BUCKETS];

  state_t            state_r, state_nxt;
  logic [BKT_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [BKT_W-1:0]  bucket_r;
  row_t              row_rd_r;
  logic              out_vld_r, out_vld_nxt;
  logic              was_r, now_r, full_r;

  logic              in_xfer;
  logic              mod_done;
  logic [BKT_W-1:0]  mod_bucket;
  logic              mem_we;
  logic [BKT_W-1:0]  mem_waddr;
  row_t              mem_wdata;
  logic              mem_re;
  logic              out_free;
  logic              upd_go;

  logic [SLT-1:0]    hit, hit_1h, free_1h;
  logic              was, now_v, full;
  row_t              row_new;

  assign in_xfer  = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free = !out_vld_r || out_tready;

  hks_bucket_mod #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BKT_W       (BKT_W)
  ) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_xfer),
    .key    (in_tdata[MODE_W +: KEY_W]),
    .done   (mod_done),
    .bucket (mod_bucket)
  );

  // slot match and lowest free slot of the bucket just read
  always_comb begin
    for (int s = 0; s < SLT; s++) begin
      hit[s] = row_rd_r.vld[s] && (row_rd_r.keys[s] == key_r);
    end
    hit_1h  = hit & (~hit + SLT'(1));
    free_1h = ~row_rd_r.vld & (row_rd_r.vld + SLT'(1));
    was     = |hit;
    now_v   = was;
    full    = 1'b0;
    row_new = row_rd_r;
    if (mode_r == MODE_INSERT && !was) begin
      if (|free_1h) begin
        now_v       = 1'b1;
        row_new.vld = row_rd_r.vld | free_1h;
        for (int s = 0; s < SLT; s++) begin
          if (free_1h[s]) begin
            row_new.keys[s] = key_r;
          end
        end
      end else begin
        full = 1'b1;
      end
    end else if (mode_r == MODE_REMOVE && was) begin
      now_v       = 1'b0;
      row_new.vld = row_rd_r.vld & ~hit_1h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    mem_we      = 1'b0;
    mem_waddr   = bucket_r;
    mem_wdata   = row_new;
    mem_re      = 1'b0;
    upd_go      = 1'b0;
    out_vld_nxt = out_vld_r && !out_tready;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we         = 1'b1;
        mem_waddr      = clr_cnt_r;
        mem_wdata.vld  = '0;
        clr_cnt_nxt    = clr_cnt_r + BKT_W'(1);
        if (clr_cnt_r == BKT_W'(NUM_BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          mem_re    = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          upd_go      = 1'b1;
          mem_we      = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      row_rd_r <= mem[mod_bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= in_tdata[MODE_W-1:0];
      key_r  <= in_tdata[MODE_W +: KEY_W];
    end
    if (mod_done) begin
      bucket_r <= mod_bucket;
    end
    if (upd_go) begin
      was_r  <= was;
      now_r  <= now_v;
      full_r <= full;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, full_r, now_r, was_r};

`ifndef SYNTH
  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[2] && (out_tdata[0] || out_tdata[1])))
    else $error("bucket_full with key present");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("second item taken while one is in flight");

  a_mod_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == ST_MOD)
    else $error("bucket result outside its wait state");

  a_lookup_const: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && mode_r != MODE_INSERT && mode_r != MODE_REMOVE) |->
      (now_v == was) && !mem_wdata.vld[0] == !row_rd_r.vld[0])
    else $error("lookup changed presence");

  a_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPDATE |-> $onehot0(hit))
    else $error("key stored in more than one slot");
`endif

endmodule

@@ hdl/hks_bucket_mod.sv @@
// ----------------------------------------------------------------------------
// hks_bucket_mod
// Three-stage pipeline that maps a key to its bucket, key modulo the bucket
// count, by a reciprocal multiply, a back multiply and one correction step.
// ----------------------------------------------------------------------------
module hks_bucket_mod
  import hks_pkg::*;
#(
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
  parameter int BKT_W       = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output logic [BKT_W-1:0] bucket
);

  localparam int SHIFT  = 28;
  localparam int RCP_W  = SHIFT + 1;
  localparam int NB_W   = $clog2(NUM_BUCKETS + 1);
  localparam int PROD_W = KEY_W + RCP_W;
  localparam int QN_W   = KEY_W + NB_W;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((2**SHIFT) / NUM_BUCKETS + 1);
  localparam logic [NB_W-1:0]  NB    = NB_W'(NUM_BUCKETS);

  logic [2:0]        vld_r;
  logic [KEY_W-1:0]  key1_r, key2_r;
  logic [KEY_W-1:0]  quot_r;
  logic [QN_W-1:0]   qn_r;
  logic [BKT_W-1:0]  bucket_r;
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  rem;
  logic [KEY_W-1:0]  rem_fix;

  assign prod = PROD_W'(key) * PROD_W'(RECIP);

  // reciprocal is rounded up so the estimate is never low; a single compare and subtract guards the remainder
  always_comb begin
    rem     = key2_r - qn_r[KEY_W-1:0];
    rem_fix = rem;
    if (rem >= KEY_W'(NB)) begin
      rem_fix = rem - KEY_W'(NB);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    key1_r   <= key;
    quot_r   <= prod[SHIFT +: KEY_W];
    key2_r   <= key1_r;
    qn_r     <= QN_W'(quot_r) * QN_W'(NB);
    bucket_r <= rem_fix[BKT_W-1:0];
  end

  assign done   = vld_r[2];
  assign bucket = bucket_r;

endmodule
